[src/rhc_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package rhc_pkg;

   // Channel width; full scale (all ones) stands for 1.0
   localparam int CHANNEL_BITS = 8;

   // Hue: 1/64 degree units, 3840 per sixth of a turn
   localparam int HUE_BITS   = 15;
   localparam int HUE_QBITS  = 12;
   localparam int HUE_FRAC   = 8;
   localparam logic [HUE_BITS-1:0] HUE_PER_SIXTH = HUE_BITS'(3840);
   localparam logic [HUE_BITS-1:0] HUE_SECTOR_G  = HUE_BITS'(7680);
   localparam logic [HUE_BITS-1:0] HUE_SECTOR_B  = HUE_BITS'(15360);
   localparam logic [HUE_BITS-1:0] HUE_FULL_TURN = HUE_BITS'(23040);

   // Divider cells: enough steps for the wider of the two quotients
   localparam int DIV_STEPS = (CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS;
   localparam logic [DIV_STEPS-1:0] HUE_FRAC_MASK =
      DIV_STEPS'((64'd1 << (DIV_STEPS - HUE_QBITS)) - 64'd1);

   // Front register, one register per cell, output register
   localparam int LATENCY = DIV_STEPS + 2;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rhc_pixel_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic                    hue_defined;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } rhc_result_type;

   // One restoring-division lane as it moves down the cell row
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] rem;
      logic [CHANNEL_BITS-1:0] divisor;
      logic [DIV_STEPS-1:0]    rest;
      logic [DIV_STEPS-1:0]    quo;
   } rhc_lane_type;

   // Side information that travels alongside the lanes
   typedef struct packed {
      logic                    valid;
      logic                    defined;
      logic                    negative;
      logic [HUE_BITS-1:0]     base;
      logic [CHANNEL_BITS-1:0] brightness;
   } rhc_tag_type;

endpackage

[src/rhc_front.sv]
// Front stage: max/min, sector, hue and saturation dividends, registered.
// Depends on rhc_pkg.
module rhc_front
   import rhc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rhc_pixel_type pixel,
   output rhc_tag_type   tag_out,
   output rhc_lane_type  hue_out,
   output rhc_lane_type  sat_out
);

   localparam int CB = CHANNEL_BITS;

   logic [CB-1:0]   hi, lo, delta, pos, neg_src, mag;
   logic [CB:0]     diff;
   logic            red_max, green_max, negative;
   logic [CB+3:0]   hue_dividend;
   logic [2*CB-1:0] sat_dividend;
   logic [HUE_BITS-1:0] base;

   rhc_tag_type  tag_in, tag_ff;
   rhc_lane_type hue_in, hue_ff, sat_in, sat_ff;

   // Winner of the maximum: red, then green, then blue on a tie
   always_comb begin
      red_max   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
      green_max = !red_max && (pixel.green >= pixel.blue);
      hi = red_max ? pixel.red : (green_max ? pixel.green : pixel.blue);
      lo = pixel.red;
      if (pixel.green < lo) lo = pixel.green;
      if (pixel.blue < lo) lo = pixel.blue;
      delta = hi - lo;

      if (red_max) begin
         pos     = pixel.green;
         neg_src = pixel.blue;
      end else if (green_max) begin
         pos     = pixel.blue;
         neg_src = pixel.red;
      end else begin
         pos     = pixel.red;
         neg_src = pixel.green;
      end

      // Signed difference, then its magnitude
      diff     = {1'b0, pos} - {1'b0, neg_src};
      negative = diff[CB];
      mag      = negative ? CB'(-diff) : diff[CB-1:0];

      // Sector base; red sector with a negative hue wraps a full turn
      if (red_max)        base = negative ? HUE_FULL_TURN : '0;
      else if (green_max) base = HUE_SECTOR_G;
      else                base = HUE_SECTOR_B;

      // |diff|*15 (times 256 by the shifted-in zeros), delta*full_scale
      hue_dividend = ({4'b0, mag} << 4) - {4'b0, mag};
      sat_dividend = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};

      tag_in.valid      = load;
      tag_in.defined    = (delta != '0);
      tag_in.negative   = negative;
      tag_in.base       = base;
      tag_in.brightness = hi;

      hue_in.rem     = hue_dividend[CB+3:4];
      hue_in.divisor = delta;
      hue_in.rest    = DIV_STEPS'(hue_dividend[3:0]) << (DIV_STEPS - 4);
      hue_in.quo     = '0;

      sat_in.rem     = sat_dividend[2*CB-1:CB];
      sat_in.divisor = hi;
      sat_in.rest    = DIV_STEPS'(sat_dividend[CB-1:0]) << (DIV_STEPS - CB);
      sat_in.quo     = '0;
   end

   // Stage register: valid bit reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.defined    <= tag_in.defined;
      tag_ff.negative   <= tag_in.negative;
      tag_ff.base       <= tag_in.base;
      tag_ff.brightness <= tag_in.brightness;
      hue_ff            <= hue_in;
      sat_ff            <= sat_in;
   end

   assign tag_out = tag_ff;
   assign hue_out = hue_ff;
   assign sat_out = sat_ff;

endmodule

[src/rhc_cell.sv]
// One divider cell: a single restoring step on both the hue and the
// saturation lane, registered. Depends on rhc_pkg.
module rhc_cell
   import rhc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rhc_tag_type  tag_in_port,
   input  rhc_lane_type hue_in_port,
   input  rhc_lane_type sat_in_port,
   output rhc_tag_type  tag_out,
   output rhc_lane_type hue_out,
   output rhc_lane_type sat_out
);

   localparam int CB = CHANNEL_BITS;

   rhc_tag_type  tag_ff;
   rhc_lane_type hue_in, hue_ff, sat_in, sat_ff;

   // Shift in the next dividend bit, subtract the divisor if it fits
   function automatic rhc_lane_type lane_step(input rhc_lane_type a);
      logic [CB:0]  trial;
      rhc_lane_type b;
      trial     = {a.rem, a.rest[DIV_STEPS-1]};
      b         = a;
      b.rest    = a.rest << 1;
      if (trial >= {1'b0, a.divisor}) begin
         b.rem = CB'(trial - {1'b0, a.divisor});
         b.quo = {a.quo[DIV_STEPS-2:0], 1'b1};
      end else begin
         b.rem = trial[CB-1:0];
         b.quo = {a.quo[DIV_STEPS-2:0], 1'b0};
      end
      return b;
   endfunction

   always_comb begin
      hue_in = lane_step(hue_in_port);
      sat_in = lane_step(sat_in_port);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in_port.valid;
      end
      tag_ff.defined    <= tag_in_port.defined;
      tag_ff.negative   <= tag_in_port.negative;
      tag_ff.base       <= tag_in_port.base;
      tag_ff.brightness <= tag_in_port.brightness;
      hue_ff            <= hue_in;
      sat_ff            <= sat_in;
   end

   assign tag_out = tag_ff;
   assign hue_out = hue_ff;
   assign sat_out = sat_ff;

endmodule

[src/rhc_finish.sv]
// Final stage: hue from sector base and quotient, saturation select,
// output register and strobe. Depends on rhc_pkg.
module rhc_finish
   import rhc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rhc_tag_type    tag_in_port,
   input  rhc_lane_type   hue_in_port,
   input  rhc_lane_type   sat_in_port,
   output logic           strobe,
   output rhc_result_type result
);

   localparam int CB = CHANNEL_BITS;

   logic [HUE_QBITS-1:0] quot;
   logic                 inexact;
   logic                 valid_in, valid_ff;
   rhc_result_type       result_in, result_ff;

   always_comb begin
      quot    = hue_in_port.quo[DIV_STEPS-1 -: HUE_QBITS];
      inexact = (hue_in_port.rem != '0) || ((hue_in_port.quo & HUE_FRAC_MASK) != '0);

      // Negative fraction floors downwards: round the quotient up
      result_in.hue = '0;
      if (tag_in_port.defined) begin
         if (tag_in_port.negative)
            result_in.hue = tag_in_port.base - HUE_BITS'(quot) - HUE_BITS'(inexact);
         else
            result_in.hue = tag_in_port.base + HUE_BITS'(quot);
      end
      result_in.hue_defined = tag_in_port.defined;
      result_in.saturation  = tag_in_port.defined ?
                              sat_in_port.quo[DIV_STEPS-1 -: CB] : '0;
      result_in.brightness  = tag_in_port.brightness;
      valid_in              = tag_in_port.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign strobe = valid_ff;
   assign result = result_ff;

endmodule

[src/rgb_to_hsv_convert_unit.sv]
// Top level of the RGB to HSV converter: front stage, divider cell row,
// finishing stage. Depends on rhc_pkg, rhc_front, rhc_cell, rhc_finish.
//
// Takes one pixel beat in every clock cycle; busy is always low. Each
// result appears on rsp_result with rsp_valid high for one cycle, in order,
// after the front register, one register per divider cell and the output
// register. A row of restoring divider cells, one quotient bit per cell,
// produces hue and saturation side by side.
// The receiver cannot stall, so results must be captured when strobed.
module rgb_to_hsv_convert_unit
   import rhc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  rhc_pixel_type  req_pixel,
   output logic           rsp_valid,
   output rhc_result_type rsp_result
);

   rhc_tag_type  tag_chain [0:DIV_STEPS];
   rhc_lane_type hue_chain [0:DIV_STEPS];
   rhc_lane_type sat_chain [0:DIV_STEPS];

   // Fully pipelined: a new beat is taken every cycle
   assign busy = 1'b0;

   rhc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .load    (start && !busy),
      .pixel   (req_pixel),
      .tag_out (tag_chain[0]),
      .hue_out (hue_chain[0]),
      .sat_out (sat_chain[0])
   );

   // Divider row, one quotient bit per cell
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rhc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .tag_in_port (tag_chain[i]),
         .hue_in_port (hue_chain[i]),
         .sat_in_port (sat_chain[i]),
         .tag_out     (tag_chain[i+1]),
         .hue_out     (hue_chain[i+1]),
         .sat_out     (sat_chain[i+1])
      );
   end

   rhc_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .tag_in_port (tag_chain[DIV_STEPS]),
      .hue_in_port (hue_chain[DIV_STEPS]),
      .sat_in_port (sat_chain[DIV_STEPS]),
      .strobe      (rsp_valid),
      .result      (rsp_result)
   );

endmodule

[src/rhc_checker.sv]
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_convert_unit.
module rhc_checker
   import rhc_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           start,
   input logic           busy,
   input rhc_pixel_type  req_pixel,
   input logic           rsp_valid,
   input rhc_result_type rsp_result
);

   // Every result beat comes from a start beat a fixed latency earlier
   a_result_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without matching start beat");

   // Gray pixels carry zero hue and zero saturation
   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result.hue_defined |->
         rsp_result.hue == '0 && rsp_result.saturation == '0)
      else $error("undefined hue with nonzero hue or saturation");

   // Hue stays inside one turn, and a defined hue means nonzero saturation
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result.hue < HUE_FULL_TURN &&
         (!rsp_result.hue_defined || rsp_result.saturation != '0))
      else $error("hue out of range or saturation inconsistent");

   // Brightness is no less than any channel of the matching pixel
   a_brightness_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result.brightness >= $past(req_pixel.red, LATENCY) &&
         rsp_result.brightness >= $past(req_pixel.green, LATENCY) &&
         rsp_result.brightness >= $past(req_pixel.blue, LATENCY))
      else $error("brightness below a channel of its pixel");

endmodule

bind rgb_to_hsv_convert_unit rhc_checker u_rhc_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for rgb_to_hsv_convert_unit: directed pixel table, then random pixels.
// Depends on rhc_pkg and the converter RTL; a built-in predictor or the typed-in expectation checks every result beat.
`timescale 1ns / 1ps

module tb_top;
   import rhc_pkg::*;

   // Hue scale: 3840 units per sixth of a turn
   localparam int HUE_SIXTH      = 3840;
   localparam int HUE_TURN       = 23040;
   localparam int SIXTHS_RED     = 0;
   localparam int SIXTHS_GREEN   = 2;
   localparam int SIXTHS_BLUE    = 4;
   localparam int FULL_SCALE     = (1 << CHANNEL_BITS) - 1;
   localparam int PIXEL_BITS     = $bits(rhc_pixel_type);
   localparam int RANDOM_PIXELS  = 2000;
   localparam int MAX_GAP        = 10;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;

   // One directed beat; the typed-in expectation is used only when has_want is set
   typedef struct {
      rhc_pixel_type  px;
      bit             has_want;
      rhc_result_type want;
   } pixel_row_type;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   rhc_pixel_type  req_pixel;
   logic           rsp_valid;
   rhc_result_type rsp_result;

   // Expectation carried alongside the beat being offered
   bit             row_typed;
   rhc_result_type row_expect;

   rhc_result_type hsv_expect_q[$];
   rhc_result_type hsv_want;
   pixel_row_type  directed_rows[$];
   int unsigned    cycle_count;
   int unsigned    mismatch_count;
   int unsigned    results_seen;
   int unsigned    undefined_seen;
   int unsigned    pixels_sent;
   bit             burst_mode;

   rgb_to_hsv_convert_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Predictor: value, saturation and floored hue in 1/64 degree
   function automatic rhc_result_type predict_hsv(input rhc_pixel_type px);
      rhc_result_type res;
      int             rr, gg, bb, hi, lo, delta, sector, diff;
      longint         num;
      rr    = int'(px.red);
      gg    = int'(px.green);
      bb    = int'(px.blue);
      hi    = rr;
      if (gg > hi) hi = gg;
      if (bb > hi) hi = bb;
      lo    = rr;
      if (gg < lo) lo = gg;
      if (bb < lo) lo = bb;
      delta = hi - lo;
      res   = '0;
      res.brightness = CHANNEL_BITS'(hi);
      if (hi != 0) res.saturation = CHANNEL_BITS'((delta * FULL_SCALE) / hi);
      if (delta != 0) begin
         // red wins a tie over green, green over blue
         if (rr == hi) begin
            sector = SIXTHS_RED;
            diff   = gg - bb;
         end else if (gg == hi) begin
            sector = SIXTHS_GREEN;
            diff   = bb - rr;
         end else begin
            sector = SIXTHS_BLUE;
            diff   = rr - gg;
         end
         num = longint'(HUE_SIXTH) * longint'(sector * delta + diff);
         if (num < 0) num += longint'(HUE_TURN) * longint'(delta);
         res.hue         = HUE_BITS'(num / longint'(delta));
         res.hue_defined = 1'b1;
      end
      return res;
   endfunction

   function automatic pixel_row_type mk_row(input int r, input int g, input int b,
                                            input bit has_want, input int hue,
                                            input bit hdef, input int sat, input int val);
      pixel_row_type row;
      row.px.red                 = CHANNEL_BITS'(r);
      row.px.green               = CHANNEL_BITS'(g);
      row.px.blue                = CHANNEL_BITS'(b);
      row.has_want               = has_want;
      row.want.hue               = HUE_BITS'(hue);
      row.want.hue_defined       = hdef;
      row.want.saturation        = CHANNEL_BITS'(sat);
      row.want.brightness        = CHANNEL_BITS'(val);
      return row;
   endfunction

   // Random pixels biased towards gray, ties, extremes and tiny deltas
   function automatic rhc_pixel_type random_pixel();
      rhc_pixel_type px;
      int            v, low, base, k;
      int            ch[3];
      case ($urandom_range(0, 9))
         0: begin
            v  = $urandom_range(0, FULL_SCALE);
            px = {CHANNEL_BITS'(v), CHANNEL_BITS'(v), CHANNEL_BITS'(v)};
         end
         1, 2: begin
            v   = $urandom_range(1, FULL_SCALE);
            low = $urandom_range(0, v - 1);
            case ($urandom_range(0, 2))
               0:       px = {CHANNEL_BITS'(v), CHANNEL_BITS'(v), CHANNEL_BITS'(low)};
               1:       px = {CHANNEL_BITS'(low), CHANNEL_BITS'(v), CHANNEL_BITS'(v)};
               default: px = {CHANNEL_BITS'(v), CHANNEL_BITS'(low), CHANNEL_BITS'(v)};
            endcase
         end
         3: begin
            for (k = 0; k < 3; k++) begin
               case ($urandom_range(0, 5))
                  0:       ch[k] = 0;
                  1:       ch[k] = 1;
                  2:       ch[k] = FULL_SCALE / 2;
                  3:       ch[k] = FULL_SCALE / 2 + 1;
                  4:       ch[k] = FULL_SCALE - 1;
                  default: ch[k] = FULL_SCALE;
               endcase
            end
            px = {CHANNEL_BITS'(ch[0]), CHANNEL_BITS'(ch[1]), CHANNEL_BITS'(ch[2])};
         end
         4: begin
            base = $urandom_range(2, FULL_SCALE - 2);
            for (k = 0; k < 3; k++) ch[k] = base + int'($urandom_range(0, 4)) - 2;
            px = {CHANNEL_BITS'(ch[0]), CHANNEL_BITS'(ch[1]), CHANNEL_BITS'(ch[2])};
         end
         default: px = rhc_pixel_type'(PIXEL_BITS'($urandom()));
      endcase
      return px;
   endfunction

   function automatic int unsigned draw_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Offer one pixel beat at the falling edge and hold it until taken
   task automatic drive_pixel(input rhc_pixel_type px, input bit typed,
                              input rhc_result_type want, input int unsigned gap);
      if (gap != 0) begin
         start     = 1'b0;
         row_typed = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      = 1'b1;
      req_pixel  = px;
      row_typed  = typed;
      row_expect = want;
      do @(posedge clock); while (busy);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Result checker and expectation capture, sampled at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, hsv_expect_q.size());
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (hsv_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Unexpected result beat: hue %0d def %0d sat %0d val %0d",
                           rsp_result.hue, rsp_result.hue_defined,
                           rsp_result.saturation, rsp_result.brightness);
            end else begin
               hsv_want = hsv_expect_q.pop_front();
               results_seen++;
               if (!hsv_want.hue_defined) undefined_seen++;
               if (rsp_result.hue !== hsv_want.hue ||
                   rsp_result.hue_defined !== hsv_want.hue_defined ||
                   rsp_result.saturation !== hsv_want.saturation ||
                   rsp_result.brightness !== hsv_want.brightness) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("Mismatch on result %0d: exp hue %0d def %0d sat %0d val %0d, %s",
                              results_seen, hsv_want.hue, hsv_want.hue_defined,
                              hsv_want.saturation, hsv_want.brightness,
                              $sformatf("got hue %0d def %0d sat %0d val %0d",
                                        rsp_result.hue, rsp_result.hue_defined,
                                        rsp_result.saturation, rsp_result.brightness));
               end
            end
         end
         if (start && !busy) begin
            if (row_typed) hsv_expect_q.push_back(row_expect);
            else           hsv_expect_q.push_back(predict_hsv(req_pixel));
         end
      end
   end

   // Stimulus: reset, directed table, random pixels, drain
   initial begin : stimulus
      int unsigned   i;
      pixel_row_type row;
      reset          = 1'b1;
      start          = 1'b0;
      req_pixel      = '0;
      row_typed      = 1'b0;
      row_expect     = '0;
      cycle_count    = 0;
      mismatch_count = 0;
      results_seen   = 0;
      undefined_seen = 0;
      pixels_sent    = 0;
      burst_mode     = 1'b0;

      // black, white and grays: hue undefined
      directed_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(255, 255, 255, 1, 0, 0, 0, 255));
      directed_rows.push_back(mk_row(1, 1, 1, 1, 0, 0, 0, 1));
      directed_rows.push_back(mk_row(128, 128, 128, 1, 0, 0, 0, 128));
      // primaries at full scale and a faint red
      directed_rows.push_back(mk_row(255, 0, 0, 1, 0, 1, 255, 255));
      directed_rows.push_back(mk_row(0, 255, 0, 1, 7680, 1, 255, 255));
      directed_rows.push_back(mk_row(0, 0, 255, 1, 15360, 1, 255, 255));
      directed_rows.push_back(mk_row(1, 0, 0, 1, 0, 1, 255, 1));
      // ties for the maximum
      directed_rows.push_back(mk_row(255, 255, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 255, 255, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(255, 0, 255, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(200, 200, 100, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(100, 200, 200, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(200, 100, 200, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(1, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(0, 1, 1, 0, 0, 0, 0, 0));
      // negative hue that wraps, and small deltas
      directed_rows.push_back(mk_row(255, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(255, 254, 254, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(254, 255, 253, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(255, 1, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(128, 64, 200, 0, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[j]) begin
         row = directed_rows[j];
         drive_pixel(row.px, row.has_want, row.want, draw_gap());
      end

      for (i = 0; i < RANDOM_PIXELS; i++) begin
         // stretches of back-to-back beats between gappy ones
         if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         drive_pixel(random_pixel(), 1'b0, '0, draw_gap());
      end
      start     = 1'b0;
      row_typed = 1'b0;

      while (hsv_expect_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      mismatch_count += hsv_expect_q.size();
      $display("Checked %0d results from %0d pixel beats (%0d directed), %0d mismatches.",
               results_seen, pixels_sent, directed_rows.size(), mismatch_count);
      $display("Covered gray, tied, extreme and near-gray pixels; %0d with hue undefined.",
               undefined_seen);
      if (mismatch_count == 0) $display("== PASS ==");
      else                     $display("== FAIL ==");
      $finish;
   end

endmodule
